>>> hdl/cla_pkg.sv
// ----------------------------------------------------------------------------
// Clustered light assigner package
// Shared codes, command and result types, and state types.
// ----------------------------------------------------------------------------
package cla_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int FRAC_SHIFT = 14;

    localparam logic [2:0] ACT_CLEAR      = 3'd0;
    localparam logic [2:0] ACT_LOAD       = 3'd1;
    localparam logic [2:0] ACT_ADD        = 3'd2;
    localparam logic [2:0] ACT_FINISH     = 3'd3;
    localparam logic [2:0] ACT_RD_CLUSTER = 3'd4;
    localparam logic [2:0] ACT_RD_LIGHT   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    localparam logic [2:0] CFG_CLUSTERS = 3'd0;
    localparam logic [2:0] CFG_CAP      = 3'd1;
    localparam logic [2:0] CFG_X_ROT    = 3'd2;
    localparam logic [2:0] CFG_X_SHIFT  = 3'd3;
    localparam logic [2:0] CFG_Y_ROT    = 3'd4;
    localparam logic [2:0] CFG_Y_SHIFT  = 3'd5;
    localparam logic [2:0] CFG_Z_ROT    = 3'd6;
    localparam logic [2:0] CFG_Z_SHIFT  = 3'd7;

    typedef struct packed {
        logic [2:0]       action;
        logic [16:0]      read_address;
        logic [5:0][31:0] box;
        logic [2:0][31:0] ctr;
        logic [31:0]      radius;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] cluster_offset;
        logic [5:0]  cluster_lights;
        logic [9:0]  light_number;
    } t_res;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ACC,
        F_RND,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_SWEEP,
        B_FIN,
        B_RDCL,
        B_RDLT,
        B_REPLY
    } t_bstate;

endpackage

>>> hdl/cla_in_if.sv
// ----------------------------------------------------------------------------
// Clustered light assigner input channel
// Valid/ready channel carrying one input item per beat.
// ----------------------------------------------------------------------------
interface cla_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [16:0]        read_address;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic signed [31:0] light_radius;

    modport source (
        output valid, action, read_address, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z, light_x, light_y, light_z,
               light_radius,
        input  ready
    );
    modport sink (
        input  valid, action, read_address, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z, light_x, light_y, light_z,
               light_radius,
        output ready
    );
endinterface

>>> hdl/cla_out_if.sv
// ----------------------------------------------------------------------------
// Clustered light assigner output channel
// Valid/ready channel carrying one result item per beat.
// ----------------------------------------------------------------------------
interface cla_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [17:0] cluster_offset;
    logic [5:0]  cluster_lights;
    logic [9:0]  light_number;

    modport source (
        output valid, status, cluster_offset, cluster_lights, light_number,
        input  ready
    );
    modport sink (
        input  valid, status, cluster_offset, cluster_lights, light_number,
        output ready
    );
endinterface

>>> hdl/clustered_light_assigner_top.sv
// ----------------------------------------------------------------------------
// Clustered light assigner
// Assigns point lights to view-space cluster boxes and serves the resulting
// per-cluster light lists.
// ----------------------------------------------------------------------------
// The front end takes one input beat at a time; a light stays there for its
// view transform, done on one shared 16x32 multiplier. The back end then
// sweeps the loaded boxes one per cycle: an add sweeps min(boxes loaded,
// clusters in use) boxes, a finish the clusters in use and a clear all
// MAX_CLUSTERS hit counts. A two-entry queue lets the front transform the
// next light while the back sweeps. After reset, a clearing pass zeroes the
// hit counts; no input beat is taken until it ends.
module clustered_light_assigner_top #(
    parameter int MAX_CLUSTERS = 4096,
    parameter int MAX_LIGHTS   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    cla_in_if.sink      i_in,
    cla_out_if.source   o_out
);

    localparam int NW = $clog2(MAX_CLUSTERS + 1);

    logic [12:0]      r_cluster_count;
    logic [5:0]       r_cap;
    logic [2:0][47:0] r_rot;
    logic [2:0][31:0] r_shift;

    logic [NW-1:0]    w_n;
    logic [5:0]       w_cap;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    logic             w_init_busy;
    cla_pkg::t_cmd    w_cmd_in;
    cla_pkg::t_cmd    w_cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= 13'd4096;
            r_cap           <= 6'd32;
            r_rot[0]        <= 48'd16384;
            r_rot[1]        <= 48'd1073741824;
            r_rot[2]        <= 48'd70368744177664;
            r_shift         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cla_pkg::CFG_CLUSTERS: r_cluster_count <= i_cfg_data[12:0];
                cla_pkg::CFG_CAP:      r_cap           <= i_cfg_data[5:0];
                cla_pkg::CFG_X_ROT:    r_rot[0]        <= i_cfg_data;
                cla_pkg::CFG_X_SHIFT:  r_shift[0]      <= i_cfg_data[31:0];
                cla_pkg::CFG_Y_ROT:    r_rot[1]        <= i_cfg_data;
                cla_pkg::CFG_Y_SHIFT:  r_shift[1]      <= i_cfg_data[31:0];
                cla_pkg::CFG_Z_ROT:    r_rot[2]        <= i_cfg_data;
                cla_pkg::CFG_Z_SHIFT:  r_shift[2]      <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (32'(r_cluster_count) > 32'(MAX_CLUSTERS)) begin
            w_n = NW'(MAX_CLUSTERS);
        end else begin
            w_n = NW'(r_cluster_count);
        end
        w_cap = (r_cap > 6'(cla_pkg::MAX_SLOTS)) ? 6'(cla_pkg::MAX_SLOTS) : r_cap;
    end

    cla_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (w_init_busy),
        .i_rot   (r_rot),
        .i_shift (r_shift),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in),
        .i_in    (i_in)
    );

    cla_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    cla_back #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_LIGHTS   (MAX_LIGHTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (w_n),
        .i_cap       (w_cap),
        .i_empty     (w_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("Command pushed into a full queue.");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("Command popped from an empty queue.");

    a_no_beat_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !i_in.ready) else $error("Input taken during clearing pass.");
`endif

endmodule

>>> hdl/cla_front.sv
// ----------------------------------------------------------------------------
// Clustered light assigner front end
// Accepts input beats, moves the centers of lights with a positive radius into
// view space with one shared multiplier, then hands a command to the queue.
// ----------------------------------------------------------------------------
module cla_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic [2:0][47:0]  i_rot,
    input  logic [2:0][31:0]  i_shift,
    input  logic              i_full,
    output logic              o_push,
    output cla_pkg::t_cmd     o_cmd,
    cla_in_if.sink            i_in
);

    localparam logic signed [50:0] SAT_HI = 51'sh7FFF_FFFF;
    localparam logic signed [50:0] SAT_LO = ~SAT_HI;
    localparam logic signed [50:0] RND_BIAS = 51'sd8192;

    cla_pkg::t_fstate   r_state;
    cla_pkg::t_fstate   n_state;
    cla_pkg::t_cmd      r_cmd;
    logic [2:0][31:0]   r_pos;
    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic signed [50:0] r_acc;
    logic signed [47:0] r_prod;

    logic signed [15:0] w_coef;
    logic signed [31:0] w_pt;
    logic signed [47:0] w_prod;
    logic signed [50:0] w_rnd;
    logic [31:0]        w_sat;
    logic [1:0]         w_next_row;
    logic               w_take;

    assign w_coef = i_rot[r_row][{r_col, 4'b0000} +: 16];
    assign w_pt   = r_pos[r_col];
    assign w_prod = w_coef * w_pt;
    assign w_rnd  = (r_acc + RND_BIAS) >>> cla_pkg::FRAC_SHIFT;
    assign w_next_row = (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;

    always_comb begin
        if (w_rnd > SAT_HI) begin
            w_sat = SAT_HI[31:0];
        end else if (w_rnd < SAT_LO) begin
            w_sat = SAT_LO[31:0];
        end else begin
            w_sat = w_rnd[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cla_pkg::F_IDLE: begin
                if (i_in.valid && !i_hold) begin
                    if (i_in.action == cla_pkg::ACT_ADD && i_in.light_radius > 32'sd0) begin
                        n_state = cla_pkg::F_MUL;
                    end else begin
                        n_state = cla_pkg::F_PUSH;
                    end
                end
            end
            cla_pkg::F_MUL: n_state = cla_pkg::F_ACC;
            cla_pkg::F_ACC: begin
                n_state = (r_col == 2'd2) ? cla_pkg::F_RND : cla_pkg::F_MUL;
            end
            cla_pkg::F_RND: begin
                n_state = (r_row == 2'd2) ? cla_pkg::F_PUSH : cla_pkg::F_MUL;
            end
            cla_pkg::F_PUSH: begin
                if (!i_full) begin
                    n_state = cla_pkg::F_IDLE;
                end
            end
            default: n_state = cla_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == cla_pkg::F_IDLE) && !i_hold;
        o_push     = (r_state == cla_pkg::F_PUSH) && !i_full;
        w_take     = i_in.valid && i_in.ready;
    end

    assign o_cmd = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cla_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.action       <= i_in.action;
            r_cmd.read_address <= i_in.read_address;
            r_cmd.box[0]       <= i_in.box_min_x;
            r_cmd.box[1]       <= i_in.box_min_y;
            r_cmd.box[2]       <= i_in.box_min_z;
            r_cmd.box[3]       <= i_in.box_max_x;
            r_cmd.box[4]       <= i_in.box_max_y;
            r_cmd.box[5]       <= i_in.box_max_z;
            r_cmd.radius       <= i_in.light_radius;
            r_pos[0]           <= i_in.light_x;
            r_pos[1]           <= i_in.light_y;
            r_pos[2]           <= i_in.light_z;
            r_row              <= 2'd0;
            r_col              <= 2'd0;
            r_acc              <= {{5{i_shift[0][31]}}, i_shift[0], 14'b0};
        end
        if (r_state == cla_pkg::F_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == cla_pkg::F_ACC) begin
            r_acc <= r_acc + 51'(r_prod);
            r_col <= r_col + 2'd1;
        end
        if (r_state == cla_pkg::F_RND) begin
            r_cmd.ctr[r_row] <= w_sat;
            r_row <= w_next_row;
            r_col <= 2'd0;
            r_acc <= {{5{i_shift[w_next_row][31]}}, i_shift[w_next_row], 14'b0};
        end
    end

endmodule

>>> hdl/cla_fifo.sv
// ----------------------------------------------------------------------------
// Clustered light assigner command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cla_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cla_pkg::t_cmd i_data,
    input  logic          i_pop,
    output cla_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);

    cla_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/cla_back.sv
// ----------------------------------------------------------------------------
// Clustered light assigner back end
// Owns the box, count, slot and offset memories and carries out commands:
// box sweeps for lights, prefix sweeps for finish, clears, loads and reads.
// ----------------------------------------------------------------------------
module cla_back #(
    parameter int MAX_CLUSTERS,
    parameter int MAX_LIGHTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_CLUSTERS+1)-1:0]   i_n,
    input  logic [5:0]                          i_cap,
    input  logic                                i_empty,
    input  cla_pkg::t_cmd                       i_cmd,
    output logic                                o_pop,
    output logic                                o_init_busy,
    cla_out_if.source                           o_out
);

    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int NW = $clog2(MAX_CLUSTERS + 1);
    localparam int LW = $clog2(MAX_LIGHTS + 1);
    localparam int SLOTS = MAX_CLUSTERS * cla_pkg::MAX_SLOTS;

    logic [5:0][31:0] m_box  [MAX_CLUSTERS];
    logic [5:0]       m_cnt  [MAX_CLUSTERS];
    logic [9:0]       m_slot [SLOTS];
    logic [17:0]      m_pre  [MAX_CLUSTERS];

    cla_pkg::t_bstate r_state;
    cla_pkg::t_bstate n_state;
    cla_pkg::t_cmd    r_cmd;
    cla_pkg::t_res    r_res;
    cla_pkg::t_res    r_out;
    logic             r_ov;
    logic [NW-1:0]    r_boxes;
    logic [LW-1:0]    r_lights;
    logic [9:0]       r_light_id;
    logic [NW-1:0]    r_idx;
    logic [NW-1:0]    r_lim;
    logic [30:0]      r_radius;
    logic [61:0]      r_r2;
    logic [17:0]      r_run;

    logic [5:0][31:0] r_box_rd;
    logic [5:0]       r_cnt_rd;
    logic [9:0]       r_slot_rd;
    logic [17:0]      r_pre_rd;

    logic             r_v1;
    logic [IW-1:0]    r_i1;
    logic             r_v2;
    logic [IW-1:0]    r_i2;
    logic [5:0]       r_c2;
    logic             r_ok2;
    logic [2:0][30:0] r_ad2;
    logic             r_v3;
    logic [IW-1:0]    r_i3;
    logic [5:0]       r_c3;
    logic             r_ok3;
    logic [2:0][61:0] r_sq3;
    logic             r_fv;
    logic [IW-1:0]    r_fi;

    logic [IW-1:0]    w_cnt_ra;
    logic [IW-1:0]    w_cl_idx;
    logic [11:0]      w_cl;
    logic             w_cnt_we;
    logic [IW-1:0]    w_cnt_wa;
    logic [5:0]       w_cnt_wd;
    logic             w_hit;
    logic [63:0]      w_sum;
    logic [2:0][30:0] w_ad;
    logic [2:0]       w_over;
    logic             w_full;
    logic             w_ovf;
    logic             w_rpos;
    logic             w_rdcl_bad;
    logic             w_rdlt_bad;
    logic             w_sw_issue;
    logic             w_fin_issue;
    logic             w_out_free;

    assign w_cl       = i_cmd.read_address[16:5];
    assign w_cl_idx   = IW'(w_cl);
    assign w_full     = (r_boxes >= i_n);
    assign w_ovf      = (32'(r_lights) >= 32'(MAX_LIGHTS));
    assign w_rpos     = ($signed(i_cmd.radius) > 32'sd0);
    assign w_rdcl_bad = (32'(i_cmd.read_address) >= 32'(i_n));
    assign w_rdlt_bad = (32'(w_cl) >= 32'(i_n));
    assign w_sw_issue = (r_state == cla_pkg::B_SWEEP) && (r_idx < r_lim);
    assign w_fin_issue = (r_state == cla_pkg::B_FIN) && (r_idx < i_n);
    assign w_out_free = !r_ov || o_out.ready;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [31:0] c;
            logic signed [31:0] q;
            logic signed [32:0] d;
            logic [32:0]        ad;
            c = r_cmd.ctr[a];
            q = c;
            if (q < $signed(r_box_rd[a])) begin
                q = r_box_rd[a];
            end
            if (q > $signed(r_box_rd[a + 3])) begin
                q = r_box_rd[a + 3];
            end
            d = 33'(q) - 33'(c);
            ad = d[32] ? 33'(-d) : 33'(d);
            w_over[a] = (ad > {2'b00, r_radius});
            w_ad[a] = ad[30:0];
        end
    end

    assign w_sum = 64'(r_sq3[0]) + 64'(r_sq3[1]) + 64'(r_sq3[2]);
    assign w_hit = r_v3 && r_ok3 && (w_sum <= 64'(r_r2)) && (r_c3 < i_cap);

    always_comb begin
        case (r_state)
            cla_pkg::B_IDLE: begin
                w_cnt_ra = (i_cmd.action == cla_pkg::ACT_RD_LIGHT)
                         ? w_cl_idx : IW'(i_cmd.read_address);
            end
            default: w_cnt_ra = r_idx[IW-1:0];
        endcase
    end

    always_comb begin
        w_cnt_we = 1'b0;
        w_cnt_wa = r_idx[IW-1:0];
        w_cnt_wd = 6'd0;
        if (r_state == cla_pkg::B_INIT || r_state == cla_pkg::B_CLEAR) begin
            w_cnt_we = 1'b1;
        end else if (w_hit) begin
            w_cnt_we = 1'b1;
            w_cnt_wa = r_i3;
            w_cnt_wd = r_c3 + 6'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cla_pkg::B_INIT: begin
                if (r_idx == NW'(MAX_CLUSTERS - 1)) begin
                    n_state = cla_pkg::B_IDLE;
                end
            end
            cla_pkg::B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.action)
                        cla_pkg::ACT_CLEAR:  n_state = cla_pkg::B_CLEAR;
                        cla_pkg::ACT_ADD: begin
                            n_state = (!w_ovf && w_rpos) ? cla_pkg::B_SWEEP
                                                         : cla_pkg::B_REPLY;
                        end
                        cla_pkg::ACT_FINISH: n_state = cla_pkg::B_FIN;
                        cla_pkg::ACT_RD_CLUSTER: begin
                            n_state = w_rdcl_bad ? cla_pkg::B_REPLY : cla_pkg::B_RDCL;
                        end
                        cla_pkg::ACT_RD_LIGHT: begin
                            n_state = w_rdlt_bad ? cla_pkg::B_REPLY : cla_pkg::B_RDLT;
                        end
                        default: n_state = cla_pkg::B_REPLY;
                    endcase
                end
            end
            cla_pkg::B_CLEAR: begin
                if (r_idx == NW'(MAX_CLUSTERS - 1)) begin
                    n_state = cla_pkg::B_REPLY;
                end
            end
            cla_pkg::B_SWEEP: begin
                if (!w_sw_issue && !r_v1 && !r_v2 && !r_v3) begin
                    n_state = cla_pkg::B_REPLY;
                end
            end
            cla_pkg::B_FIN: begin
                if (!w_fin_issue && !r_fv) begin
                    n_state = cla_pkg::B_REPLY;
                end
            end
            cla_pkg::B_RDCL: n_state = cla_pkg::B_REPLY;
            cla_pkg::B_RDLT: n_state = cla_pkg::B_REPLY;
            cla_pkg::B_REPLY: begin
                if (w_out_free) begin
                    n_state = cla_pkg::B_IDLE;
                end
            end
            default: n_state = cla_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == cla_pkg::B_IDLE) && !i_empty;
        o_init_busy = (r_state == cla_pkg::B_INIT);
    end

    assign o_out.valid          = r_ov;
    assign o_out.status         = r_out.status;
    assign o_out.cluster_offset = r_out.cluster_offset;
    assign o_out.cluster_lights = r_out.cluster_lights;
    assign o_out.light_number   = r_out.light_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cla_pkg::B_INIT;
            r_idx    <= '0;
            r_boxes  <= '0;
            r_lights <= '0;
            r_ov     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_fv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1 <= w_sw_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_fv <= w_fin_issue;
            if (r_state == cla_pkg::B_INIT || r_state == cla_pkg::B_CLEAR
                || w_sw_issue || w_fin_issue) begin
                r_idx <= r_idx + NW'(1);
            end
            if (o_pop) begin
                r_idx <= '0;
                unique case (i_cmd.action)
                    cla_pkg::ACT_CLEAR: begin
                        r_boxes  <= '0;
                        r_lights <= '0;
                    end
                    cla_pkg::ACT_LOAD: begin
                        if (!w_full) begin
                            r_boxes <= r_boxes + NW'(1);
                        end
                    end
                    cla_pkg::ACT_ADD: begin
                        if (!w_ovf) begin
                            r_lights <= r_lights + LW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == cla_pkg::B_REPLY && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd      <= i_cmd;
            r_res      <= '0;
            r_light_id <= 10'(r_lights);
            r_lim      <= (r_boxes < i_n) ? r_boxes : i_n;
            r_radius   <= i_cmd.radius[30:0];
            r_r2       <= i_cmd.radius[30:0] * i_cmd.radius[30:0];
            r_run      <= 18'd0;
            case (i_cmd.action)
                cla_pkg::ACT_LOAD: begin
                    if (w_full) begin
                        r_res.status <= cla_pkg::ST_FULL;
                    end
                end
                cla_pkg::ACT_ADD: begin
                    if (w_ovf) begin
                        r_res.status <= cla_pkg::ST_OVF;
                    end
                end
                cla_pkg::ACT_RD_CLUSTER: begin
                    if (w_rdcl_bad) begin
                        r_res.status <= cla_pkg::ST_RANGE;
                    end
                end
                cla_pkg::ACT_RD_LIGHT: begin
                    if (w_rdlt_bad) begin
                        r_res.status <= cla_pkg::ST_RANGE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == cla_pkg::B_RDCL) begin
            r_res.cluster_offset <= r_pre_rd;
            r_res.cluster_lights <= r_cnt_rd;
        end
        if (r_state == cla_pkg::B_RDLT) begin
            if ({1'b0, r_cmd.read_address[cla_pkg::SLOT_W-1:0]} >= r_cnt_rd) begin
                r_res.status <= cla_pkg::ST_RANGE;
            end else begin
                r_res.light_number <= r_slot_rd;
            end
        end
        if (r_state == cla_pkg::B_FIN) begin
            r_res.cluster_offset <= r_run;
        end
        if (r_fv) begin
            r_run <= r_run + 18'(r_cnt_rd);
        end
        if (r_state == cla_pkg::B_REPLY && w_out_free) begin
            r_out <= r_res;
        end

        r_i1  <= r_idx[IW-1:0];
        r_i2  <= r_i1;
        r_c2  <= r_cnt_rd;
        r_ok2 <= ~|w_over;
        r_ad2 <= w_ad;
        r_i3  <= r_i2;
        r_c3  <= r_c2;
        r_ok3 <= r_ok2;
        for (int a = 0; a < 3; a++) begin
            r_sq3[a] <= r_ad2[a] * r_ad2[a];
        end
        r_fi <= r_idx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_cnt_rd  <= m_cnt[w_cnt_ra];
        r_box_rd  <= m_box[r_idx[IW-1:0]];
        r_pre_rd  <= m_pre[IW'(i_cmd.read_address)];
        r_slot_rd <= m_slot[{w_cl_idx, i_cmd.read_address[cla_pkg::SLOT_W-1:0]}];
        if (w_cnt_we) begin
            m_cnt[w_cnt_wa] <= w_cnt_wd;
        end
        if (o_pop && i_cmd.action == cla_pkg::ACT_LOAD && !w_full) begin
            m_box[r_boxes[IW-1:0]] <= i_cmd.box;
        end
        if (w_hit) begin
            m_slot[{r_i3, r_c3[cla_pkg::SLOT_W-1:0]}] <= r_light_id;
        end
        if (r_fv) begin
            m_pre[r_fi] <= r_run;
        end
    end

endmodule

>>> verif/cla_light_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clustered light assignment predictor
// Keeps its own copy of the box table, the per-cluster light lists and the
// configuration, and checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
class cla_light_scoreboard;

    localparam int N_CLUSTERS = 4096;
    localparam int N_LIGHTS   = 1024;

    logic signed [31:0] boxes[N_CLUSTERS][6];
    logic [5:0]         counts[N_CLUSTERS];
    logic [9:0]         slots[N_CLUSTERS * cla_pkg::MAX_SLOTS];
    logic [17:0]        offsets[N_CLUSTERS];
    int                 n_boxes;
    int                 n_lights;

    logic [12:0]        clusters_reg;
    logic [5:0]         cap_reg;
    logic [47:0]        rot[3];
    logic signed [31:0] shift[3];

    cla_pkg::t_res      pending[$];
    int                 mismatches;

    function new();
        foreach (counts[i]) begin
            counts[i] = '0;
            offsets[i] = '0;
        end
        n_boxes = 0;
        n_lights = 0;
        clusters_reg = 13'd4096;
        cap_reg = 6'd32;
        rot[0] = 48'd16384;
        rot[1] = 48'd1073741824;
        rot[2] = 48'd70368744177664;
        foreach (shift[i]) shift[i] = '0;
        mismatches = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [47:0] data);
        case (idx)
            cla_pkg::CFG_CLUSTERS: clusters_reg = data[12:0];
            cla_pkg::CFG_CAP:      cap_reg = data[5:0];
            cla_pkg::CFG_X_ROT:    rot[0] = data;
            cla_pkg::CFG_X_SHIFT:  shift[0] = data[31:0];
            cla_pkg::CFG_Y_ROT:    rot[1] = data;
            cla_pkg::CFG_Y_SHIFT:  shift[1] = data[31:0];
            cla_pkg::CFG_Z_ROT:    rot[2] = data;
            default:               shift[2] = data[31:0];
        endcase
    endfunction

    function int in_use();
        return (clusters_reg > N_CLUSTERS) ? N_CLUSTERS : int'(clusters_reg);
    endfunction

    function longint view_coord(int row, longint p[3]);
        longint acc;
        longint c;
        acc = longint'(shift[row]) * 16384;
        for (int k = 0; k < 3; k++) begin
            c = longint'($signed(rot[row][16*k +: 16]));
            acc += c * p[k];
        end
        acc += 8192;
        acc = acc >>> 14;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc;
    endfunction

    function bit sphere_hits(int b, longint ctr[3], longint r);
        longint q, d;
        longint unsigned sum;
        sum = 0;
        for (int a = 0; a < 3; a++) begin
            q = ctr[a];
            if (q < boxes[b][a]) q = boxes[b][a];
            if (q > boxes[b][a + 3]) q = boxes[b][a + 3];
            d = q - ctr[a];
            if (d < 0) d = -d;
            if (d > r) return 0;
            sum += $unsigned(d * d);
        end
        return (sum <= $unsigned(r * r));
    endfunction

    function void note_input(cla_pkg::t_cmd c);
        cla_pkg::t_res res;
        int n, lim, cap, run, cl, sl;
        longint p[3], ctr[3], r;
        res = '0;
        n = in_use();
        case (c.action)
            cla_pkg::ACT_CLEAR: begin
                foreach (counts[i]) counts[i] = '0;
                n_boxes = 0;
                n_lights = 0;
            end
            cla_pkg::ACT_LOAD: begin
                if (n_boxes >= n) begin
                    res.status = cla_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < 6; i++) boxes[n_boxes][i] = c.box[i];
                    n_boxes++;
                end
            end
            cla_pkg::ACT_ADD: begin
                if (n_lights >= N_LIGHTS) begin
                    res.status = cla_pkg::ST_OVF;
                end else begin
                    r = longint'($signed(c.radius));
                    if (r > 0) begin
                        lim = (n_boxes < n) ? n_boxes : n;
                        cap = (cap_reg > cla_pkg::MAX_SLOTS) ? cla_pkg::MAX_SLOTS
                                                             : int'(cap_reg);
                        for (int i = 0; i < 3; i++) p[i] = longint'($signed(c.ctr[i]));
                        for (int i = 0; i < 3; i++) ctr[i] = view_coord(i, p);
                        for (int i = 0; i < lim; i++) begin
                            if (counts[i] < cap && sphere_hits(i, ctr, r)) begin
                                slots[i * cla_pkg::MAX_SLOTS + counts[i]] = n_lights[9:0];
                                counts[i]++;
                            end
                        end
                    end
                    n_lights++;
                end
            end
            cla_pkg::ACT_FINISH: begin
                run = 0;
                for (int i = 0; i < n; i++) begin
                    offsets[i] = run[17:0];
                    run += counts[i];
                end
                res.cluster_offset = run[17:0];
            end
            cla_pkg::ACT_RD_CLUSTER: begin
                if (c.read_address >= n) begin
                    res.status = cla_pkg::ST_RANGE;
                end else begin
                    res.cluster_offset = offsets[c.read_address];
                    res.cluster_lights = counts[c.read_address];
                end
            end
            cla_pkg::ACT_RD_LIGHT: begin
                cl = c.read_address / cla_pkg::MAX_SLOTS;
                sl = c.read_address % cla_pkg::MAX_SLOTS;
                if (cl >= n || sl >= counts[cl])
                    res.status = cla_pkg::ST_RANGE;
                else
                    res.light_number = slots[cl * cla_pkg::MAX_SLOTS + sl];
            end
            default: ;
        endcase
        pending = {pending, res};
    endfunction

    function void check_result(cla_pkg::t_res got);
        cla_pkg::t_res exp_res;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat %p", got);
            return;
        end
        exp_res = pending.pop_front();
        if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_res, got);
        end
    endfunction

endclass

>>> verif/clustered_light_assigner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clustered light assigner testbench
// Loads froxel boxes, adds lights under several view transforms and cluster
// settings, then reads back offsets and light lists, checking every beat.
// ----------------------------------------------------------------------------
module clustered_light_assigner_top_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    int          send_idle;
    int          recv_stall;
    int          n_sent;

    cla_in_if  in_ch();
    cla_out_if out_ch();
    cla_light_scoreboard board;

    clustered_light_assigner_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                board.check_result({out_ch.status, out_ch.cluster_offset,
                                    out_ch.cluster_lights, out_ch.light_number});
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_item(cla_pkg::t_cmd c);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= c.action;
        in_ch.read_address <= c.read_address;
        in_ch.box_min_x    <= c.box[0];
        in_ch.box_min_y    <= c.box[1];
        in_ch.box_min_z    <= c.box[2];
        in_ch.box_max_x    <= c.box[3];
        in_ch.box_max_y    <= c.box[4];
        in_ch.box_max_z    <= c.box[5];
        in_ch.light_x      <= c.ctr[0];
        in_ch.light_y      <= c.ctr[1];
        in_ch.light_z      <= c.ctr[2];
        in_ch.light_radius <= c.radius;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_input(c);
        n_sent++;
    endtask

    task automatic act(logic [2:0] a, logic [16:0] addr);
        cla_pkg::t_cmd c;
        c = '0;
        c.action = a;
        c.read_address = addr;
        c.box = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c.ctr = {$urandom, $urandom, $urandom};
        c.radius = $urandom;
        send_item(c);
    endtask

    task automatic load_box(logic signed [31:0] lo, logic signed [31:0] hi, int spread);
        cla_pkg::t_cmd c;
        logic signed [31:0] a, b;
        c = '0;
        c.action = cla_pkg::ACT_LOAD;
        for (int k = 0; k < 3; k++) begin
            a = lo + $signed($urandom_range(spread));
            b = hi + $signed($urandom_range(spread));
            c.box[k] = a;
            c.box[k + 3] = b;
        end
        send_item(c);
    endtask

    task automatic add_light(logic signed [31:0] pos, int spread, logic signed [31:0] r);
        cla_pkg::t_cmd c;
        c = '0;
        c.action = cla_pkg::ACT_ADD;
        c.read_address = 17'($urandom);
        for (int k = 0; k < 3; k++) c.ctr[k] = pos + $signed($urandom_range(spread));
        c.radius = r;
        send_item(c);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n_items, int n_cl);
        int pick;
        act(cla_pkg::ACT_CLEAR, 17'd0);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (n_sent < 8 || pick < 25)
                load_box(-32'sd200000, 32'sd150000 + $urandom_range(300000), 200000);
            else if (pick < 60)
                add_light(-32'sd100000, 300000,
                          ($urandom_range(9) == 0) ? $signed($urandom) :
                          $signed($urandom_range(200000)));
            else if (pick < 67)
                act(cla_pkg::ACT_FINISH, 17'd0);
            else if (pick < 80)
                act(cla_pkg::ACT_RD_CLUSTER, 17'($urandom_range(n_cl + 1)));
            else if (pick < 95)
                act(cla_pkg::ACT_RD_LIGHT, 17'($urandom_range((n_cl + 1) * 32)));
            else
                act(3'($urandom_range(7)), 17'($urandom));
            if (i == 4) act(cla_pkg::ACT_FINISH, 17'd0);
        end
    endtask

    initial begin
        cla_pkg::t_cmd c;
        board = new();
        n_sent = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = cla_pkg::CFG_CLUSTERS;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = cla_pkg::ACT_CLEAR;
        in_ch.read_address = '0;
        {in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} = '0;
        {in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} = '0;
        {in_ch.light_x, in_ch.light_y, in_ch.light_z, in_ch.light_radius} = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset configuration.
        act(cla_pkg::ACT_FINISH, 17'd0);
        c = '0;
        c.action = cla_pkg::ACT_LOAD;
        c.box = {32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_item(c);
        c.box = {32'sh80000000, 32'sh00010000, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh00000000, 32'sh80000000};
        send_item(c);
        load_box(-32'sd1000, 32'sd1000, 5000);
        add_light(0, 0, 32'sh7fffffff);
        add_light(32'sh7fffffff, 0, 32'sh00010000);
        add_light(32'sh80000000, 0, 32'sh7fffffff);
        add_light(0, 100, 0);
        add_light(0, 100, 32'sh80000000);
        add_light(0, 0, 32'sd1000);
        act(cla_pkg::ACT_FINISH, 17'd0);
        act(cla_pkg::ACT_RD_CLUSTER, 17'd0);
        act(cla_pkg::ACT_RD_CLUSTER, 17'd2);
        act(cla_pkg::ACT_RD_CLUSTER, 17'h1ffff);
        act(cla_pkg::ACT_RD_LIGHT, 17'd0);
        act(cla_pkg::ACT_RD_LIGHT, 17'd1);
        act(cla_pkg::ACT_RD_LIGHT, 17'd65);
        act(cla_pkg::ACT_RD_LIGHT, 17'h1ffff);
        act(3'd6, 17'h1ffff);
        act(3'd7, 17'd0);
        settle();

        // Tiny grid with zero cap, extreme transforms and a full table.
        write_reg(cla_pkg::CFG_CLUSTERS, 48'd1);
        write_reg(cla_pkg::CFG_CAP, 48'd0);
        write_reg(cla_pkg::CFG_X_ROT, 48'hffffffffffff);
        write_reg(cla_pkg::CFG_X_SHIFT, 48'h7fffffff);
        write_reg(cla_pkg::CFG_Y_ROT, 48'h800080008000);
        write_reg(cla_pkg::CFG_Y_SHIFT, 48'h80000000);
        write_reg(cla_pkg::CFG_Z_ROT, 48'h7fff7fff7fff);
        write_reg(cla_pkg::CFG_Z_SHIFT, 48'hffffffff);
        act(cla_pkg::ACT_CLEAR, 17'd0);
        load_box(0, 0, 10);
        load_box(0, 0, 10);
        add_light(32'sh7fffffff, 0, 32'sh7fffffff);
        add_light(32'sh80000000, 0, 32'sh7fffffff);
        act(cla_pkg::ACT_FINISH, 17'd0);
        act(cla_pkg::ACT_RD_CLUSTER, 17'd0);
        for (int i = 0; i < 6; i++) add_light(0, 10, (i % 3 == 0) ? 32'sd0 : 32'sd5);
        act(cla_pkg::ACT_FINISH, 17'd0);
        settle();

        write_reg(cla_pkg::CFG_CLUSTERS, 48'h1fff);
        write_reg(cla_pkg::CFG_CAP, 48'h3f);
        write_reg(cla_pkg::CFG_X_ROT, 48'd16384);
        write_reg(cla_pkg::CFG_X_SHIFT, 48'd0);
        write_reg(cla_pkg::CFG_Y_ROT, 48'd1073741824);
        write_reg(cla_pkg::CFG_Y_SHIFT, 48'd0);
        write_reg(cla_pkg::CFG_Z_ROT, 48'd70368744177664);
        write_reg(cla_pkg::CFG_Z_SHIFT, 48'd0);
        act(cla_pkg::ACT_CLEAR, 17'd0);
        act(cla_pkg::ACT_FINISH, 17'd0);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 79) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 79) : 0;
            write_reg(cla_pkg::CFG_CLUSTERS, 48'd4 + $urandom_range(12));
            write_reg(cla_pkg::CFG_CAP, 48'($urandom_range(6)));
            write_reg(cla_pkg::CFG_X_ROT,
                      {$urandom_range(65535), 16'($urandom_range(20000))});
            write_reg(cla_pkg::CFG_X_SHIFT, 48'($signed($urandom_range(40000)) - 20000));
            write_reg(cla_pkg::CFG_Y_ROT,
                      {16'($urandom), 16'($urandom_range(20000) + 8000), 16'($urandom)});
            write_reg(cla_pkg::CFG_Y_SHIFT, 48'($urandom_range(40000)));
            write_reg(cla_pkg::CFG_Z_ROT, {16'($urandom_range(20000)), 32'($urandom)});
            write_reg(cla_pkg::CFG_Z_SHIFT, 48'($urandom));
            random_phase(25, 16);
            settle();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cla_pkg.sv
hdl/cla_in_if.sv
hdl/cla_out_if.sv
hdl/cla_front.sv
hdl/cla_fifo.sv
hdl/cla_back.sv
hdl/clustered_light_assigner_top.sv
verif/cla_light_scoreboard.sv
verif/clustered_light_assigner_top_tb.sv
